FILE: rtl/core/touch_tap_drag_tracker_macros.svh
// ----------------------------------------------------------------------------
// Touch tap/drag tracker assertion macros
// Shared assertion wrappers used at the end of the tracker's top level.
// ----------------------------------------------------------------------------
`ifndef TOUCH_TAP_DRAG_TRACKER_MACROS_SVH
`define TOUCH_TAP_DRAG_TRACKER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TDT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define TDT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tdt_pkg.sv
// ----------------------------------------------------------------------------
// Touch tap/drag tracker package
// Field widths, panel constants, scaling reciprocals and shared types.
// ----------------------------------------------------------------------------
package tdt_pkg;

	localparam int PANEL_WIDTH  = 1280;
	localparam int PANEL_HEIGHT = 720;

	localparam int RAW_X_W   = 11;
	localparam int RAW_Y_W   = 10;
	localparam int DSZ_W     = 13;
	localparam int SLOP_W    = 8;
	localparam int DT_W      = 16;
	localparam int POS_W     = 16;
	localparam int DELTA_W   = 17;
	localparam int HELD_W    = 32;
	localparam int CFG_IDX_W = 2;

	// Scaled numerator is raw * design * 16.
	localparam int PX_W    = RAW_X_W + DSZ_W;
	localparam int PY_W    = RAW_Y_W + DSZ_W;
	localparam int NUM_X_W = PX_W + 4;
	localparam int NUM_Y_W = PY_W + 4;

	// Exact floor division by the panel size: multiply by floor(2^K/P)+1 and
	// shift right by K, with K = numerator width + ceil(log2(P)).
	localparam int SHIFT_X = NUM_X_W + $clog2(PANEL_WIDTH);
	localparam int SHIFT_Y = NUM_Y_W + $clog2(PANEL_HEIGHT);
	localparam int PRODX_W = 2 * NUM_X_W + 1;
	localparam int PRODY_W = 2 * NUM_Y_W + 1;
	localparam int QX_W    = PRODX_W - SHIFT_X;
	localparam int QY_W    = PRODY_W - SHIFT_Y;

	typedef logic [NUM_X_W:0]   recip_x_t;
	typedef logic [NUM_Y_W:0]   recip_y_t;
	typedef logic [PRODX_W-1:0] prod_x_t;
	typedef logic [PRODY_W-1:0] prod_y_t;

	localparam recip_x_t RECIP_X = recip_x_t'((64'd1 << SHIFT_X) / PANEL_WIDTH + 64'd1);
	localparam recip_y_t RECIP_Y = recip_y_t'((64'd1 << SHIFT_Y) / PANEL_HEIGHT + 64'd1);

	localparam logic [POS_W-1:0]  POS_MAX  = '1;
	localparam logic [HELD_W-1:0] HELD_MAX = '1;

	localparam logic [DSZ_W-1:0]  DESIGN_WIDTH_RST  = DSZ_W'(1280);
	localparam logic [DSZ_W-1:0]  DESIGN_HEIGHT_RST = DSZ_W'(720);
	localparam logic [SLOP_W-1:0] TAP_SLOP_RST      = SLOP_W'(18);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DESIGN_WIDTH  = 2'd0,
		REG_DESIGN_HEIGHT = 2'd1,
		REG_TAP_SLOP      = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_FORGET = 1'b1
	} cmd_t;

	typedef struct packed {
		logic pressed;
		logic released;
		logic is_down;
	} evt_t;

	// How the sticky drag flag moves for one transfer.
	typedef struct packed {
		logic clr;
		logic upd;
	} drag_ctl_t;

endpackage

FILE: rtl/core/touch_tap_drag_tracker.sv
// ----------------------------------------------------------------------------
// Touch tap/drag tracker
// Scales one touch sample per transfer to design space and reports edges,
// position, motion, held time and a sticky drag flag.
// ----------------------------------------------------------------------------
// Usage:
// A sample transfer happens on a clock edge with sample_valid high and
// sample_stall low; a result transfer the same way on result_valid and
// result_stall. Every sample gives exactly one result, in order.
// The block takes one sample per cycle while sample_stall is low. A result
// appears once its sample has passed six registers (input register, two
// multiplier stages for the scaling, the touch record update, the travel
// squares, and the result register).
// The touch record sits in one stage, so back-to-back samples see each
// other's updates without any bubble.
// When the receiver stalls, the result register holds and the stages behind
// it keep filling; sample_stall rises only once all six stages are full.
// Reset clears the touch record and the pipeline and loads the design size
// 1280 x 720 and tap slop 18. The cfg port writes a register on cfg_wen;
// the user must write it only while no sample is in flight (unenforced).
// ----------------------------------------------------------------------------
`include "touch_tap_drag_tracker_macros.svh"

module touch_tap_drag_tracker import tdt_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DSZ_W-1:0]            cfg_data,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic                        command,
	input  logic                        touching,
	input  logic [RAW_X_W-1:0]          raw_x,
	input  logic [RAW_Y_W-1:0]          raw_y,
	input  logic [DT_W-1:0]             elapsed_us,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        pressed,
	output logic                        released,
	output logic                        is_down,
	output logic [POS_W-1:0]            pos_x,
	output logic [POS_W-1:0]            pos_y,
	output logic [POS_W-1:0]            origin_x,
	output logic [POS_W-1:0]            origin_y,
	output logic signed [DELTA_W-1:0]   delta_x,
	output logic signed [DELTA_W-1:0]   delta_y,
	output logic [HELD_W-1:0]           held_us,
	output logic                        dragged
);

	// Configuration registers
	logic [DSZ_W-1:0]  dw_q, dh_q;
	logic [SLOP_W-1:0] slop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q   <= DESIGN_WIDTH_RST;
			dh_q   <= DESIGN_HEIGHT_RST;
			slop_q <= TAP_SLOP_RST;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_DESIGN_WIDTH:  dw_q   <= cfg_data;
				REG_DESIGN_HEIGHT: dh_q   <= cfg_data;
				REG_TAP_SLOP:      slop_q <= cfg_data[SLOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_s6;

	assign rdy_s6 = !v_s6 || !result_stall;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign ld_s1 = rdy_s1 && sample_valid;
	assign ld_s2 = rdy_s2 && v_s1;
	assign ld_s3 = rdy_s3 && v_s2;
	assign ld_s4 = rdy_s4 && v_s3;
	assign ld_s5 = rdy_s5 && v_s4;
	assign ld_s6 = rdy_s6 && v_s5;

	assign sample_stall = !rdy_s1;
	assign result_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= sample_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: input register
	cmd_t              cmd_s1;
	logic              touch_s1;
	logic [RAW_X_W-1:0] rx_s1;
	logic [RAW_Y_W-1:0] ry_s1;
	logic [DT_W-1:0]    dt_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			cmd_s1   <= cmd_t'(command);
			touch_s1 <= touching;
			rx_s1    <= raw_x;
			ry_s1    <= raw_y;
			dt_s1    <= elapsed_us;
		end
	end

	// Stage 2: raw * design size
	cmd_t            cmd_s2;
	logic            touch_s2;
	logic [DT_W-1:0] dt_s2;
	logic [PX_W-1:0] px_s2;
	logic [PY_W-1:0] py_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			cmd_s2   <= cmd_s1;
			touch_s2 <= touch_s1;
			dt_s2    <= dt_s1;
			px_s2    <= PX_W'(rx_s1) * PX_W'(dw_q);
			py_s2    <= PY_W'(ry_s1) * PY_W'(dh_q);
		end
	end

	// Stage 3: divide by the panel size through the reciprocal
	prod_x_t         mx;
	prod_y_t         my;
	cmd_t            cmd_s3;
	logic            touch_s3;
	logic [DT_W-1:0] dt_s3;
	logic [QX_W-1:0] qx_s3;
	logic [QY_W-1:0] qy_s3;

	assign mx = prod_x_t'({px_s2, 4'b0000}) * prod_x_t'(RECIP_X);
	assign my = prod_y_t'({py_s2, 4'b0000}) * prod_y_t'(RECIP_Y);

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			cmd_s3   <= cmd_s2;
			touch_s3 <= touch_s2;
			dt_s3    <= dt_s2;
			qx_s3    <= mx[PRODX_W-1:SHIFT_X];
			qy_s3    <= my[PRODY_W-1:SHIFT_Y];
		end
	end

	// Stage 4: touch record update
	logic              was_q, ign_q;
	logic [POS_W-1:0]  last_x_q, last_y_q, start_x_q, start_y_q;
	logic [HELD_W-1:0] held_q;

	logic              was_n, ign_n;
	logic [POS_W-1:0]  last_x_n, last_y_n, start_x_n, start_y_n;
	logic [HELD_W-1:0] held_n;
	logic [POS_W-1:0]  x_sat, y_sat;
	logic [HELD_W:0]   held_sum;
	logic              live, down;
	evt_t              evt;
	drag_ctl_t         ctl;
	logic signed [DELTA_W-1:0] dx, dy, tx, ty;

	assign x_sat    = (|qx_s3[QX_W-1:POS_W]) ? POS_MAX : qx_s3[POS_W-1:0];
	assign y_sat    = (|qy_s3[QY_W-1:POS_W]) ? POS_MAX : qy_s3[POS_W-1:0];
	assign held_sum = {1'b0, held_q} + (HELD_W+1)'(dt_s3);

	always_comb begin
		// A forget command, or a touch while ignoring, wipes the record.
		live     = (cmd_s3 == CMD_SAMPLE) && !(ign_q && touch_s3);
		down     = live && touch_s3;
		evt.is_down  = down;
		evt.pressed  = down && !was_q;
		evt.released = live && !touch_s3 && was_q;
		ign_n     = (cmd_s3 == CMD_FORGET) || (ign_q && touch_s3);
		was_n     = down;
		last_x_n  = last_x_q;
		last_y_n  = last_y_q;
		start_x_n = start_x_q;
		start_y_n = start_y_q;
		held_n    = held_q;
		dx        = '0;
		dy        = '0;
		if (!live) begin
			last_x_n  = '0;
			last_y_n  = '0;
			start_x_n = '0;
			start_y_n = '0;
			held_n    = '0;
		end else if (down) begin
			if (evt.pressed) begin
				start_x_n = x_sat;
				start_y_n = y_sat;
				held_n    = '0;
			end else begin
				dx     = $signed({1'b0, x_sat}) - $signed({1'b0, last_x_q});
				dy     = $signed({1'b0, y_sat}) - $signed({1'b0, last_y_q});
				held_n = held_sum[HELD_W] ? HELD_MAX : held_sum[HELD_W-1:0];
			end
			last_x_n = x_sat;
			last_y_n = y_sat;
		end
		tx      = $signed({1'b0, x_sat}) - $signed({1'b0, start_x_n});
		ty      = $signed({1'b0, y_sat}) - $signed({1'b0, start_y_n});
		ctl.clr = !live || evt.pressed;
		ctl.upd = down;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_q     <= 1'b0;
			ign_q     <= 1'b0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			held_q    <= '0;
		end else if (ld_s4) begin
			was_q     <= was_n;
			ign_q     <= ign_n;
			last_x_q  <= last_x_n;
			last_y_q  <= last_y_n;
			start_x_q <= start_x_n;
			start_y_q <= start_y_n;
			held_q    <= held_n;
		end
	end

	evt_t                      evt_s4;
	drag_ctl_t                 ctl_s4;
	logic [POS_W-1:0]          pos_x_s4, pos_y_s4, org_x_s4, org_y_s4;
	logic signed [DELTA_W-1:0] dx_s4, dy_s4, tx_s4, ty_s4;
	logic [HELD_W-1:0]         held_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			evt_s4   <= evt;
			ctl_s4   <= ctl;
			pos_x_s4 <= last_x_n;
			pos_y_s4 <= last_y_n;
			org_x_s4 <= start_x_n;
			org_y_s4 <= start_y_n;
			dx_s4    <= dx;
			dy_s4    <= dy;
			tx_s4    <= tx;
			ty_s4    <= ty;
			held_s4  <= held_n;
		end
	end

	// Stage 5: squared travel and squared slop
	logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
	evt_t                        evt_s5;
	drag_ctl_t                   ctl_s5;
	logic [POS_W-1:0]            pos_x_s5, pos_y_s5, org_x_s5, org_y_s5;
	logic signed [DELTA_W-1:0]   dx_s5, dy_s5;
	logic [HELD_W-1:0]           held_s5;
	logic [2*POS_W-1:0]          sqx_s5, sqy_s5;
	logic [2*SLOP_W-1:0]         lim_s5;

	assign sqx_full = tx_s4 * tx_s4;
	assign sqy_full = ty_s4 * ty_s4;

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			evt_s5   <= evt_s4;
			ctl_s5   <= ctl_s4;
			pos_x_s5 <= pos_x_s4;
			pos_y_s5 <= pos_y_s4;
			org_x_s5 <= org_x_s4;
			org_y_s5 <= org_y_s4;
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
			held_s5  <= held_s4;
			// Travel never exceeds the full 16-bit span, so the square fits.
			sqx_s5   <= sqx_full[2*POS_W-1:0];
			sqy_s5   <= sqy_full[2*POS_W-1:0];
			lim_s5   <= (2*SLOP_W)'(slop_q) * (2*SLOP_W)'(slop_q);
		end
	end

	// Stage 6: slop compare, sticky drag flag and result register
	logic [2*POS_W:0] travel;
	logic             exceed, drag_q, drag_n;

	assign travel = {1'b0, sqx_s5} + {1'b0, sqy_s5};
	// The slop is in whole pixels; positions carry four fraction bits.
	assign exceed = travel > (2*POS_W+1)'({lim_s5, 8'h00});
	assign drag_n = (ctl_s5.clr ? 1'b0 : drag_q) | (ctl_s5.upd & exceed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_q <= 1'b0;
		end else if (ld_s6) begin
			drag_q <= drag_n;
		end
	end

	evt_t                      evt_s6;
	logic [POS_W-1:0]          pos_x_s6, pos_y_s6, org_x_s6, org_y_s6;
	logic signed [DELTA_W-1:0] dx_s6, dy_s6;
	logic [HELD_W-1:0]         held_s6;
	logic                      drag_s6;

	always_ff @(posedge clk) begin
		if (ld_s6) begin
			evt_s6   <= evt_s5;
			pos_x_s6 <= pos_x_s5;
			pos_y_s6 <= pos_y_s5;
			org_x_s6 <= org_x_s5;
			org_y_s6 <= org_y_s5;
			dx_s6    <= dx_s5;
			dy_s6    <= dy_s5;
			held_s6  <= held_s5;
			drag_s6  <= drag_n;
		end
	end

	assign pressed  = evt_s6.pressed;
	assign released = evt_s6.released;
	assign is_down  = evt_s6.is_down;
	assign pos_x    = pos_x_s6;
	assign pos_y    = pos_y_s6;
	assign origin_x = org_x_s6;
	assign origin_y = org_y_s6;
	assign delta_x  = dx_s6;
	assign delta_y  = dy_s6;
	assign held_us  = held_s6;
	assign dragged  = drag_s6;

	// Checks
	`TDT_ASSERT_IMP(a_press_fresh, clk, arst_n, result_valid && pressed, is_down && !released && held_us == '0 && delta_x == '0 && delta_y == '0, "press result does not start a fresh touch")
	`TDT_ASSERT_IMP(a_up_still, clk, arst_n, result_valid && !is_down, !pressed && delta_x == '0 && delta_y == '0, "result without a finger shows motion")
	`TDT_ASSERT_IMP(a_ignore_up, clk, arst_n, ign_q, !was_q, "touch record is down while ignoring the panel")
	`TDT_ASSERT(a_stall_full, clk, arst_n, !sample_stall || (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && result_valid && result_stall), "sample stalled with room in the pipeline")

endmodule
